>>> hdl/cba_pkg.sv
// Shared types and constants for the compacting bump allocator.
// Holds command, status and result kind codes and the sequencer state type.
// No dependencies.
package cba_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int OFF_W = 16;
  localparam int LEN_W = 17;
  localparam logic [LEN_W-1:0] POOL_LIMIT = 17'd65536;
  localparam logic [LEN_W-1:0] POOL_RESET = 17'd65536;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_COMPACT = 2'd2,
    CMD_LOCK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_ALLOC = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_MOVE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_STEP,
    S_FINISH
  } state_t;

endpackage

>>> hdl/compacting_bump_allocator.sv
// Compacting bump allocator: allocate, release, lock and compact over a 16-entry handle table.
// Allocate, release and set-lock register their result in S_EXEC once the output is free.
// Compact runs two passes, each scanning the table once per valid entry and once more.
// The walk uses one comparator that selects the lowest unvisited offset, one entry per cycle.
// Synchronous active-high reset clears valid and lock marks, top pointer and control state.
// Depends on cba_pkg.
module compacting_bump_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [cba_pkg::LEN_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [3:0]                  handle,
  input  logic [cba_pkg::LEN_W-1:0]   request_size,
  input  logic                        lock_flag,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [1:0]                  kind,
  output logic [cba_pkg::OFF_W-1:0]   dest_offset,
  output logic [cba_pkg::OFF_W-1:0]   source_offset,
  output logic [cba_pkg::LEN_W-1:0]   length,
  output logic [cba_pkg::LEN_W-1:0]   new_top,
  output logic                        last
);
  import cba_pkg::*;

  state_t state, state_next;

  logic [LEN_W-1:0] pool_words;
  logic [LEN_W-1:0] top_pointer;
  logic [OFF_W-1:0] entry_offset [ENTRIES];
  logic [LEN_W-1:0] entry_length [ENTRIES];
  logic [ENTRIES-1:0] entry_locked;
  logic [ENTRIES-1:0] entry_valid;

  cmd_t cmd;
  logic [IDX_W-1:0] hnd;
  logic [LEN_W-1:0] req_size;
  logic lock_req;

  logic [ENTRIES-1:0] visited;
  logic pass;
  logic [IDX_W-1:0] idx;
  logic found;
  logic [OFF_W-1:0] best_off;
  logic [IDX_W-1:0] best_idx;
  logic [LEN_W-1:0] free_mark;
  logic [LEN_W-1:0] final_top;

  logic [IDX_W-1:0] rd_idx;
  logic [OFF_W-1:0] rd_off;
  logic [LEN_W-1:0] rd_len;
  logic [LEN_W-1:0] lim;
  logic [LEN_W-1:0] op_a;
  logic [LEN_W-1:0] sum;
  logic alloc_fail;
  logic take;
  logic step_locked;
  logic out_free;

  logic emit;
  status_t e_status;
  kind_t e_kind;
  logic [OFF_W-1:0] e_dest;
  logic [OFF_W-1:0] e_src;
  logic [LEN_W-1:0] e_len;
  logic [LEN_W-1:0] e_top;
  logic e_last;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (state)
      S_SCAN:  rd_idx = idx;
      S_STEP:  rd_idx = best_idx;
      default: rd_idx = hnd;
    endcase
  end

  assign rd_off = entry_offset[rd_idx];
  assign rd_len = entry_length[rd_idx];
  assign step_locked = entry_locked[best_idx];
  assign lim = (pool_words > POOL_LIMIT) ? POOL_LIMIT : pool_words;
  assign alloc_fail = (req_size == '0) || (top_pointer > lim) || (req_size > lim - top_pointer);
  assign op_a = ((state == S_EXEC) || step_locked) ? {1'b0, rd_off} : free_mark;
  assign sum = op_a + rd_len;
  assign take = entry_valid[idx] && !visited[idx] && (!found || (rd_off < best_off));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit = 1'b0;
    e_status = ST_OK;
    e_kind = KIND_DONE;
    e_dest = '0;
    e_src = '0;
    e_len = '0;
    e_top = top_pointer;
    e_last = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (cmd_t'(command) == CMD_COMPACT) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          emit = 1'b1;
          state_next = S_IDLE;
          case (cmd)
            CMD_ALLOC: begin
              if (entry_valid[hnd]) begin
                e_status = ST_BUSY;
              end else if (alloc_fail) begin
                e_status = ST_NO_SPACE;
              end else begin
                e_dest = top_pointer[OFF_W-1:0];
                e_len = req_size;
                e_top = top_pointer + req_size;
              end
            end
            CMD_RELEASE: begin
              if (!entry_valid[hnd]) begin
                e_status = ST_NOT_ALLOC;
              end else begin
                e_kind = KIND_CLEAR;
                e_dest = rd_off;
                e_len = rd_len;
                e_top = (sum == top_pointer) ? {1'b0, rd_off} : top_pointer;
              end
            end
            default: begin
              if (!entry_valid[hnd]) begin
                e_status = ST_NOT_ALLOC;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (idx == IDX_W'(ENTRIES - 1)) begin
          state_next = (found || take) ? S_STEP : S_FINISH;
        end
      end
      S_STEP: begin
        if (step_locked || ({1'b0, rd_off} == free_mark) || !pass) begin
          state_next = S_SCAN;
        end else if (out_free) begin
          emit = 1'b1;
          e_kind = KIND_MOVE;
          e_dest = free_mark[OFF_W-1:0];
          e_src = rd_off;
          e_len = rd_len;
          e_top = final_top;
          e_last = 1'b0;
          state_next = S_SCAN;
        end
      end
      S_FINISH: begin
        if (!pass) begin
          state_next = S_SCAN;
        end else if (out_free) begin
          emit = 1'b1;
          e_top = free_mark;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_words <= POOL_RESET;
      top_pointer <= '0;
      entry_locked <= '0;
      entry_valid <= '0;
      visited <= '0;
      pass <= 1'b0;
      idx <= '0;
      found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pool_words <= cfg_wr_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            visited <= '0;
            pass <= 1'b0;
            idx <= '0;
            found <= 1'b0;
            free_mark <= '0;
          end
        end
        S_EXEC: begin
          if (emit && (e_status == ST_OK)) begin
            top_pointer <= e_top;
            case (cmd)
              CMD_ALLOC: begin
                entry_offset[hnd] <= top_pointer[OFF_W-1:0];
                entry_length[hnd] <= req_size;
                entry_locked[hnd] <= 1'b0;
                entry_valid[hnd] <= 1'b1;
              end
              CMD_RELEASE: begin
                entry_locked[hnd] <= 1'b0;
                entry_valid[hnd] <= 1'b0;
              end
              CMD_LOCK: begin
                entry_locked[hnd] <= lock_req;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (take) begin
            found <= 1'b1;
            best_off <= rd_off;
            best_idx <= idx;
          end
          idx <= (idx == IDX_W'(ENTRIES - 1)) ? '0 : idx + 1'b1;
        end
        S_STEP: begin
          if (state_next != S_STEP) begin
            visited[best_idx] <= 1'b1;
            found <= 1'b0;
            if (step_locked) begin
              if (sum > free_mark) begin
                free_mark <= sum;
              end
            end else begin
              free_mark <= sum;
            end
            if (emit) begin
              entry_offset[best_idx] <= free_mark[OFF_W-1:0];
            end
          end
        end
        S_FINISH: begin
          if (!pass) begin
            final_top <= free_mark;
            pass <= 1'b1;
            visited <= '0;
            free_mark <= '0;
          end else if (emit) begin
            top_pointer <= free_mark;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd <= cmd_t'(command);
      hnd <= handle;
      req_size <= request_size;
      lock_req <= lock_flag;
    end
    if (emit) begin
      status <= e_status;
      kind <= e_kind;
      dest_offset <= e_dest;
      source_offset <= e_src;
      length <= e_len;
      new_top <= e_top;
      last <= e_last;
    end
  end

`ifndef SYNTHESIS
  a_move_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_MOVE) |-> !last && (status == ST_OK))
    else $error("Move result marked last or not ok.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("Block ready again right after a transfer.");

  a_move_only_compact: assert property (@(posedge clk) disable iff (rst)
    emit && (e_kind == KIND_MOVE) |-> (cmd == CMD_COMPACT) && pass)
    else $error("Move emitted outside the second compaction pass.");

  a_reset_top: assert property (@(posedge clk)
    rst |=> (top_pointer == '0) && !out_valid && (entry_valid == '0))
    else $error("Reset did not clear the allocator state.");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for compacting_bump_allocator: a queue-fed driver and a
// monitor compare every result transfer against a built-in allocator predictor.
// Depends on cba_pkg and the compacting_bump_allocator RTL.
module tb_top;
  import cba_pkg::*;

  typedef struct {
    cmd_t cmd;
    logic [3:0] hnd;
    logic [LEN_W-1:0] size;
    logic lk;
  } request_t;

  typedef struct {
    status_t status;
    kind_t kind;
    logic [OFF_W-1:0] dest;
    logic [OFF_W-1:0] src;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] top;
    logic last;
  } reply_t;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = '0;
  logic [3:0] handle = '0;
  logic [LEN_W-1:0] request_size = '0;
  logic lock_flag = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [1:0] kind;
  logic [OFF_W-1:0] dest_offset;
  logic [OFF_W-1:0] source_offset;
  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] new_top;
  logic last;

  request_t pending_reqs[$];
  reply_t expected_replies[$];
  int errors = 0;
  bit quiet = 0;
  bit hold_req = 0;
  bit hold_started = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  // Predictor state.
  logic [LEN_W-1:0] pool_cfg = POOL_RESET;
  logic [OFF_W-1:0] blk_off[ENTRIES];
  logic [LEN_W-1:0] blk_len[ENTRIES];
  bit blk_locked[ENTRIES];
  bit blk_valid[ENTRIES];
  logic [LEN_W-1:0] top_ptr = '0;

  compacting_bump_allocator i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .handle(handle),
    .request_size(request_size), .lock_flag(lock_flag), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .kind(kind), .dest_offset(dest_offset),
    .source_offset(source_offset), .length(length), .new_top(new_top), .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void push_reply(status_t st, kind_t kd, logic [OFF_W-1:0] d,
                                     logic [OFF_W-1:0] s, logic [LEN_W-1:0] l,
                                     logic last_flag);
    reply_t r;
    r.status = st; r.kind = kd; r.dest = d; r.src = s; r.len = l;
    r.top = top_ptr; r.last = last_flag;
    expected_replies.push_back(r);
  endfunction

  function automatic void predict_compaction();
    int order[$];
    int first_move;
    int pos;
    logic [LEN_W-1:0] free_mark;
    logic [LEN_W-1:0] blk_end;
    free_mark = '0;
    first_move = expected_replies.size();
    for (int i = 0; i < ENTRIES; i++) begin
      if (blk_valid[i]) begin
        pos = order.size();
        while (pos > 0 && blk_off[order[pos-1]] > blk_off[i]) pos--;
        order.insert(pos, i);
      end
    end
    foreach (order[j]) begin
      if (blk_locked[order[j]]) begin
        blk_end = blk_off[order[j]] + blk_len[order[j]];
        if (blk_end > free_mark) free_mark = blk_end;
      end else begin
        if ({1'b0, blk_off[order[j]]} != free_mark) begin
          push_reply(ST_OK, KIND_MOVE, free_mark[OFF_W-1:0], blk_off[order[j]],
                     blk_len[order[j]], 1'b0);
          blk_off[order[j]] = free_mark[OFF_W-1:0];
        end
        free_mark = free_mark + blk_len[order[j]];
      end
    end
    top_ptr = free_mark;
    for (int j = first_move; j < expected_replies.size(); j++)
      expected_replies[j].top = top_ptr;
    push_reply(ST_OK, KIND_DONE, '0, '0, '0, 1'b1);
  endfunction

  function automatic void predict_allocator(request_t r);
    logic [LEN_W-1:0] usable;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    usable = (pool_cfg > POOL_LIMIT) ? POOL_LIMIT : pool_cfg;
    case (r.cmd)
      CMD_COMPACT: predict_compaction();
      CMD_ALLOC: begin
        if (blk_valid[r.hnd]) begin
          push_reply(ST_BUSY, KIND_DONE, '0, '0, '0, 1'b1);
        end else if (r.size == 0 || top_ptr > usable || r.size > usable - top_ptr) begin
          push_reply(ST_NO_SPACE, KIND_DONE, '0, '0, '0, 1'b1);
        end else begin
          off = top_ptr[OFF_W-1:0];
          blk_off[r.hnd] = off;
          blk_len[r.hnd] = r.size;
          blk_locked[r.hnd] = 0;
          blk_valid[r.hnd] = 1;
          top_ptr = top_ptr + r.size;
          push_reply(ST_OK, KIND_DONE, off, '0, r.size, 1'b1);
        end
      end
      default: begin
        if (!blk_valid[r.hnd]) begin
          push_reply(ST_NOT_ALLOC, KIND_DONE, '0, '0, '0, 1'b1);
        end else if (r.cmd == CMD_RELEASE) begin
          off = blk_off[r.hnd];
          len = blk_len[r.hnd];
          if (LEN_W'(off + len) == top_ptr) top_ptr = {1'b0, off};
          blk_valid[r.hnd] = 0;
          blk_locked[r.hnd] = 0;
          push_reply(ST_OK, KIND_CLEAR, off, '0, len, 1'b1);
        end else begin
          blk_locked[r.hnd] = r.lk;
          push_reply(ST_OK, KIND_DONE, '0, '0, '0, 1'b1);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: one payload held until its transfer, then the next one or a gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        request_t acc;
        acc.cmd = cmd_t'(command); acc.hnd = handle;
        acc.size = request_size; acc.lk = lock_flag;
        predict_allocator(acc);
      end
      if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 24)) begin
        request_t nxt;
        nxt = pending_reqs.pop_front();
        in_valid <= 1'b1;
        command <= nxt.cmd;
        handle <= nxt.hnd;
        request_size <= nxt.size;
        lock_flag <= nxt.lk;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req && !hold_started) begin
      hold_started <= 1;
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result transfer and draws the next ready value.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          reply_t w;
          w = expected_replies.pop_front();
          if (status !== w.status) report_mismatch("status", status, w.status);
          if (kind !== w.kind) report_mismatch("kind", kind, w.kind);
          if (dest_offset !== w.dest) report_mismatch("dest_offset", dest_offset, w.dest);
          if (source_offset !== w.src) report_mismatch("source_offset", source_offset, w.src);
          if (length !== w.len) report_mismatch("length", length, w.len);
          if (new_top !== w.top) report_mismatch("new_top", new_top, w.top);
          if (last !== w.last) report_mismatch("last", last, w.last);
        end
      end
      out_ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 24);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void add_req(cmd_t c, int h, logic [LEN_W-1:0] s, bit l);
    request_t r;
    r.cmd = c; r.hnd = h[3:0]; r.size = s; r.lk = l;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [LEN_W-1:0] pick_size(logic [LEN_W-1:0] pool);
    int p;
    int roll;
    p = (pool == 0) ? 1 : ((pool > 65536) ? 65536 : pool);
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 8) return LEN_W'(65536);
    if (roll < 11) return LEN_W'($urandom_range(131071, 65537));
    if (roll < 18) return LEN_W'($urandom_range(p, 1));
    return LEN_W'($urandom_range((p / 6 > 1) ? p / 6 : 1, 1));
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_pool(logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    pool_cfg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(logic [LEN_W-1:0] pool, int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 42) add_req(CMD_ALLOC, $urandom_range(15), pick_size(pool), $urandom_range(1));
      else if (roll < 65)
        add_req(CMD_RELEASE, $urandom_range(15), LEN_W'($urandom), $urandom_range(1));
      else if (roll < 86)
        add_req(CMD_LOCK, $urandom_range(15), LEN_W'($urandom), $urandom_range(1));
      else add_req(CMD_COMPACT, $urandom_range(15), LEN_W'($urandom), $urandom_range(1));
    end
  endtask

  initial begin
    logic [LEN_W-1:0] pools[7] = '{17'd65536, 17'd300, 17'd0, 17'd131071, 17'd1, 17'd16,
                                   17'd5000};
    for (int i = 0; i < ENTRIES; i++) begin
      blk_off[i] = '0; blk_len[i] = '0; blk_locked[i] = 0; blk_valid[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    add_req(CMD_ALLOC, 0, 17'd0, 0);
    add_req(CMD_ALLOC, 0, 17'd131071, 1);
    add_req(CMD_ALLOC, 0, 17'd65536, 0);
    add_req(CMD_ALLOC, 1, 17'd1, 0);
    add_req(CMD_ALLOC, 0, 17'd5, 0);
    add_req(CMD_RELEASE, 0, 17'd0, 0);
    add_req(CMD_RELEASE, 0, 17'd0, 0);
    add_req(CMD_LOCK, 2, 17'd0, 1);
    add_req(CMD_ALLOC, 0, 17'd10, 0);
    add_req(CMD_ALLOC, 1, 17'd20, 0);
    add_req(CMD_ALLOC, 2, 17'd30, 0);
    add_req(CMD_ALLOC, 3, 17'd40, 0);
    add_req(CMD_ALLOC, 15, 17'd5, 1);
    add_req(CMD_LOCK, 2, 17'd0, 1);
    add_req(CMD_RELEASE, 0, 17'd0, 0);
    add_req(CMD_RELEASE, 3, 17'd0, 0);
    add_req(CMD_COMPACT, 0, 17'd0, 0);
    add_req(CMD_LOCK, 2, 17'd0, 0);
    add_req(CMD_COMPACT, 9, 17'd131071, 1);
    add_req(CMD_RELEASE, 15, 17'd0, 0);
    add_req(CMD_COMPACT, 0, 17'd0, 0);
    add_req(CMD_LOCK, 1, 17'd0, 1);
    add_req(CMD_ALLOC, 4, 17'd65536, 0);
    wait_drained();

    foreach (pools[k]) begin
      write_pool(pools[k]);
      if (k == 3) begin
        quiet = 1;
        hold_req = 1;
      end
      random_phase(pools[k], 22);
      wait_drained();
      quiet = 0;
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> files.f
hdl/cba_pkg.sv
hdl/compacting_bump_allocator.sv
sim/tb_top.sv
